### hw/rtl/stsel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsel_pkg
// Shared types and constants of the slot table with rank select.
// ----------------------------------------------------------------------------
package stsel_pkg;

   localparam int DATA_W      = 32;
   localparam int RANK_W      = 6;
   localparam int SLOT_OUT_W  = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int RECORD_W    = 3 * DATA_W;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_GET = 2'd1,
      KIND_DEL = 2'd2,
      KIND_NOP = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   // Probe that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic              active;
      kind_type          kind;
      logic              found;
      logic [RANK_W-1:0] rank;
   } probe_type;

endpackage

### hw/rtl/stsel_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsel_req_if
// Request channel: operation code, record to add and rank to look up.
// ----------------------------------------------------------------------------
interface stsel_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] x_pos;
   logic [31:0] y_pos;
   logic [31:0] match_length;
   logic [5:0]  rank_index;

   modport source (output valid, output kind, output x_pos, output y_pos,
                   output match_length, output rank_index, input ready);
   modport sink   (input valid, input kind, input x_pos, input y_pos,
                   input match_length, input rank_index, output ready);
endinterface

### hw/rtl/stsel_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsel_rsp_if
// Response channel: status, returned record, slot touched and fill count.
// ----------------------------------------------------------------------------
interface stsel_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_length;
   logic [5:0]  slot_touched;
   logic [6:0]  used_count;

   modport source (output valid, output status, output out_x, output out_y,
                   output out_length, output slot_touched, output used_count,
                   input ready);
   modport sink   (input valid, input status, input out_x, input out_y,
                   input out_length, input slot_touched, input used_count,
                   output ready);
endinterface

### hw/rtl/slot_table_with_rank_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_with_rank_select
// Slot table of point records with lowest-free add and rank-select get/delete.
// ----------------------------------------------------------------------------
//
//  channel   port      dir  handshake     carries
//  request   req_ch    in   valid/ready   kind, x_pos, y_pos, match_length, rank_index
//  response  rsp_ch    out  valid/ready   status, out_x, out_y, out_length,
//                                         slot_touched, used_count
//
//  A request walks a chain of SLOT_COUNT cells, one cell per cycle, and the
//  block takes no new request until the walk ends and its response is loaded.
//  Requests are taken one at a time.
//  Reset clears every occupancy bit and the count; record storage is not
//  cleared. A stalled response holds in its output register while the next
//  request walks the chain; its completion waits until the response is taken.
// ----------------------------------------------------------------------------
module slot_table_with_rank_select #(
   parameter int SLOT_COUNT = 64
) (
   input  logic   clock,
   input  logic   reset,
   stsel_req_if.sink   req_ch,
   stsel_rsp_if.source rsp_ch
);

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_XW = (SLOT_W > stsel_pkg::SLOT_OUT_W) ? SLOT_W
                                                             : stsel_pkg::SLOT_OUT_W;
   localparam int COUNT_XW = (COUNT_W > stsel_pkg::COUNT_OUT_W) ? COUNT_W
                                                                : stsel_pkg::COUNT_OUT_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // probe links: entry 0 is the injection point, entry SLOT_COUNT the tail
   stsel_pkg::probe_type probe_link [SLOT_COUNT+1];
   logic [SLOT_W-1:0]    slot_link  [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0] active_vec;

   logic req_fire, rsp_fire, tail_act;
   stsel_pkg::probe_type tail;

   // request held for the memory write
   logic [stsel_pkg::DATA_W-1:0] x_ff, y_ff, len_ff;

   // record storage, read data registered
   logic [stsel_pkg::RECORD_W-1:0] rec_mem [SLOT_COUNT];
   logic [stsel_pkg::RECORD_W-1:0] rd_ff;

   // tail of the walk, kept until the response is loaded
   stsel_pkg::kind_type t_kind_ff;
   logic                t_found_ff;
   logic [SLOT_W-1:0]   t_slot_ff;

   logic [COUNT_W-1:0] count_ff, count_in;

   // response register
   logic                         res_valid_ff, res_valid_in;
   stsel_pkg::status_type        res_status_ff, res_status_in;
   logic [stsel_pkg::DATA_W-1:0] res_x_ff, res_y_ff, res_len_ff;
   logic [stsel_pkg::DATA_W-1:0] res_x_in, res_y_in, res_len_in;
   logic [SLOT_W-1:0]            res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0]           res_count_ff;
   logic                         load_res;
   logic [SLOT_XW-1:0]           slot_ext;
   logic [COUNT_XW-1:0]          count_ext;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // inject the probe straight into the first cell
   always_comb begin
      probe_link[0].active = req_fire;
      probe_link[0].kind   = stsel_pkg::kind_type'(req_ch.kind);
      probe_link[0].found  = 1'b0;
      probe_link[0].rank   = req_ch.rank_index;
      slot_link[0]         = '0;
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      stsel_cell #(
         .SLOT_W   (SLOT_W),
         .SLOT_IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_probe (probe_link[i]),
         .up_slot  (slot_link[i]),
         .dn_probe (probe_link[i+1]),
         .dn_slot  (slot_link[i+1])
      );
      assign active_vec[i] = probe_link[i+1].active;
   end

   assign tail     = probe_link[SLOT_COUNT];
   assign tail_act = tail.active;

   // hold the record of an add until the walk ends
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= req_ch.x_pos;
         y_ff   <= req_ch.y_pos;
         len_ff <= req_ch.match_length;
      end
   end

   // write on a placed add; read the found slot as the walk ends and hold it
   always_ff @(posedge clock) begin
      if (tail_act && tail.found && (tail.kind == stsel_pkg::KIND_ADD)) begin
         rec_mem[slot_link[SLOT_COUNT]] <= {x_ff, y_ff, len_ff};
      end
      if (tail_act) begin
         rd_ff <= rec_mem[slot_link[SLOT_COUNT]];
      end
   end

   // capture the tail and update the count when the walk ends
   always_comb begin
      count_in = count_ff;
      if (tail_act && tail.found) begin
         if (tail.kind == stsel_pkg::KIND_ADD) begin
            count_in = count_ff + COUNT_W'(1);
         end else if (tail.kind == stsel_pkg::KIND_DEL) begin
            count_in = count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail_act) begin
         t_kind_ff  <= tail.kind;
         t_found_ff <= tail.found;
         t_slot_ff  <= slot_link[SLOT_COUNT];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      load_res = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (tail_act) state_in = S_FIN;
         end
         S_FIN: begin
            // wait for a free response register
            if (!res_valid_ff || rsp_fire) begin
               load_res = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // build the response from the captured tail
   always_comb begin
      res_valid_in = res_valid_ff;
      if (rsp_fire) res_valid_in = 1'b0;
      if (load_res) res_valid_in = 1'b1;

      if (t_found_ff) begin
         res_status_in = stsel_pkg::STATUS_OK;
      end else if (t_kind_ff == stsel_pkg::KIND_ADD) begin
         res_status_in = stsel_pkg::STATUS_FULL;
      end else begin
         res_status_in = stsel_pkg::STATUS_ABSENT;
      end

      res_slot_in = t_found_ff ? t_slot_ff : '0;
      if (t_found_ff && (t_kind_ff == stsel_pkg::KIND_GET)) begin
         {res_x_in, res_y_in, res_len_in} = rd_ff;
      end else begin
         res_x_in   = '0;
         res_y_in   = '0;
         res_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
      if (load_res) begin
         res_status_ff <= res_status_in;
         res_x_ff      <= res_x_in;
         res_y_ff      <= res_y_in;
         res_len_ff    <= res_len_in;
         res_slot_ff   <= res_slot_in;
         res_count_ff  <= count_ff;
      end
   end

   assign slot_ext  = SLOT_XW'(res_slot_ff);
   assign count_ext = COUNT_XW'(res_count_ff);

   assign rsp_ch.valid        = res_valid_ff;
   assign rsp_ch.status       = res_status_ff;
   assign rsp_ch.out_x        = res_x_ff;
   assign rsp_ch.out_y        = res_y_ff;
   assign rsp_ch.out_length   = res_len_ff;
   assign rsp_ch.slot_touched = slot_ext[stsel_pkg::SLOT_OUT_W-1:0];
   assign rsp_ch.used_count   = count_ext[stsel_pkg::COUNT_OUT_W-1:0];

   // at most one probe in the chain
   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one probe in the cell chain");

   // a probe reaches the tail only while the walk is under way
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_act |-> (state_ff == S_SCAN))
      else $error("probe at chain tail outside scan");

   // an add can only be placed while a slot is free
   a_add_room: assert property (@(posedge clock) disable iff (reset)
      (tail_act && tail.found && (tail.kind == stsel_pkg::KIND_ADD))
         |-> (count_ff < COUNT_W'(SLOT_COUNT)))
      else $error("add placed in a full table");

   // a delete can only hit while the table holds a record
   a_del_nonempty: assert property (@(posedge clock) disable iff (reset)
      (tail_act && tail.found && (tail.kind == stsel_pkg::KIND_DEL))
         |-> (count_ff != '0))
      else $error("delete hit in an empty table");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_res && res_valid_ff) |-> rsp_fire)
      else $error("response overwritten before it was taken");

endmodule

### hw/rtl/stsel_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsel_cell
// One slot of the table: holds its occupancy bit and forwards the probe.
// ----------------------------------------------------------------------------
module stsel_cell #(
   parameter int SLOT_W   = 6,
   parameter int SLOT_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stsel_pkg::probe_type up_probe,
   input  logic [SLOT_W-1:0]    up_slot,
   output stsel_pkg::probe_type dn_probe,
   output logic [SLOT_W-1:0]    dn_slot
);

   localparam int RANK_W = stsel_pkg::RANK_W;

   logic                 occ_ff, occ_in;
   stsel_pkg::probe_type probe_ff, probe_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 seek, by_rank, hit, skip;

   always_comb begin
      seek    = up_probe.active && !up_probe.found;
      by_rank = (up_probe.kind == stsel_pkg::KIND_GET) ||
                (up_probe.kind == stsel_pkg::KIND_DEL);
      hit     = seek && (((up_probe.kind == stsel_pkg::KIND_ADD) && !occ_ff) ||
                         (by_rank && occ_ff && (up_probe.rank == '0)));
      skip    = seek && by_rank && occ_ff && (up_probe.rank != '0);

      // claim a free slot on add, release on delete
      occ_in = occ_ff;
      if (hit && (up_probe.kind == stsel_pkg::KIND_ADD)) begin
         occ_in = 1'b1;
      end
      if (hit && (up_probe.kind == stsel_pkg::KIND_DEL)) begin
         occ_in = 1'b0;
      end

      probe_in       = up_probe;
      probe_in.found = up_probe.found | hit;
      if (skip) begin
         probe_in.rank = up_probe.rank - RANK_W'(1);
      end
      slot_in = hit ? SLOT_W'(SLOT_IDX) : up_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= 1'b0;
         probe_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         probe_ff <= probe_in;
      end
      slot_ff <= slot_in;
   end

   assign dn_probe = probe_ff;
   assign dn_slot  = slot_ff;

endmodule
